// ----- rtl/world_to_screen_projection_macros.svh -----
// assertion macros for the world to screen projection block
`ifndef WORLD_TO_SCREEN_PROJECTION_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_MACROS_SVH
`ifndef NO_ASSERTIONS
// same cycle implication, disabled in reset
`define WSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsp assertion failed");
// next cycle implication, disabled in reset
`define WSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsp assertion failed");
`else
`define WSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/wsp_pkg.sv -----
// shared types and constants of the world to screen projection block
`default_nettype none
package wsp_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int SCALE_BITS     = 14;
    localparam int MAT_ENTRIES    = 16;
    localparam int CAM_ENTRIES    = 3;

    localparam logic [SCALE_BITS-1:0] WIDTH_RESET  = 14'd1920;
    localparam logic [SCALE_BITS-1:0] HEIGHT_RESET = 14'd1080;

    typedef enum logic [1:0] {
        CMD_PROJECT = 2'd0,
        CMD_VIEW    = 2'd1,
        CMD_PROJ    = 2'd2,
        CMD_CAMERA  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_VISIBLE     = 3'd0,
        ST_CAM_INVALID = 3'd1,
        ST_BEHIND      = 3'd2,
        ST_W_ZERO      = 3'd3,
        ST_OUTSIDE     = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } t_cfg_reg;

endpackage
`default_nettype wire

// ----- rtl/world_to_screen_projection.sv -----
// top level: matrix stores, transform pipeline, viewport divide and output skid
//
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_stall         i_cmd, i_elem_index, i_elem_value,
//                                                 i_point_x/y/z, i_clamp_mode
//  result    out        o_valid / i_stall         o_screen_x, o_screen_y, o_status
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one word per cycle while o_stall is low; a point passes the transform stages, the
// bit-per-stage viewport divider and the output register; coordinates are Q16.16 by default
// load words give no result; a projection load waits while a point sits in the first two
// stages, which have not yet read the projection store
// synchronous active-low reset clears valid bits and stores and sets the screen to 1920 x 1080
// a two-entry output register and skid stage keep the pipeline moving while one result waits
`default_nettype none
`include "world_to_screen_projection_macros.svh"
module world_to_screen_projection #(
    parameter int COORD_BITS = wsp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = wsp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [1:0]                          i_cmd,
    input  wire logic [3:0]                          i_elem_index,
    input  wire logic signed [COORD_BITS-1:0]        i_elem_value,
    input  wire logic signed [COORD_BITS-1:0]        i_point_x,
    input  wire logic signed [COORD_BITS-1:0]        i_point_y,
    input  wire logic signed [COORD_BITS-1:0]        i_point_z,
    input  wire logic                                i_clamp_mode,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [COORD_BITS-1:0]             o_screen_x,
    output logic signed [COORD_BITS-1:0]             o_screen_y,
    output logic [2:0]                               o_status,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic                                i_cfg_index,
    input  wire logic [wsp_pkg::SCALE_BITS-1:0]      i_cfg_data
);
    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * C;
    localparam int SB = wsp_pkg::SCALE_BITS;
    localparam int QB = SB + F + 1;
    localparam int AW = C + 1 + SB;
    localparam int DW = AW + F;
    localparam int XW = ((QB > C) ? QB : C) + 1;

    localparam logic signed [C-1:0] MAX_C = {1'b0, {(C-1){1'b1}}};
    localparam logic signed [C-1:0] MIN_C = {1'b1, {(C-1){1'b0}}};
    localparam logic [PW-1:0]       RND   = {{(PW-F){1'b0}}, {F{1'b1}}};
    localparam logic [XW-1:0]       CSIGN = XW'(1) << (C - 1);

    // product truncated toward zero by F bits, saturated
    function automatic logic signed [C-1:0] trunc_sat(input logic signed [PW-1:0] p);
        logic [PW-1:0]        adj;
        logic signed [PW-1:0] t;
        adj = p[PW-1] ? RND : '0;
        t   = (p + $signed(adj)) >>> F;
        if (t[PW-1:C-1] == '0 || t[PW-1:C-1] == '1) begin
            return t[C-1:0];
        end
        return t[PW-1] ? MIN_C : MAX_C;
    endfunction

    // four-term sum saturated once
    function automatic logic signed [C-1:0] sum_sat(input logic signed [C-1:0] a,
                                                    input logic signed [C-1:0] b,
                                                    input logic signed [C-1:0] c,
                                                    input logic signed [C-1:0] d);
        logic signed [C+1:0] s;
        s = (C+2)'(a) + (C+2)'(b) + (C+2)'(c) + (C+2)'(d);
        if (s[C+1:C-1] == '0 || s[C+1:C-1] == '1) begin
            return s[C-1:0];
        end
        return s[C+1] ? MIN_C : MAX_C;
    endfunction

    function automatic logic [C-1:0] mag_c(input logic signed [C-1:0] v);
        return v[C-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [C:0] mag_c1(input logic signed [C:0] v);
        return v[C] ? (~v + 1'b1) : v;
    endfunction

    // quotient magnitude back to a saturated signed coordinate
    function automatic logic signed [C-1:0] to_coord(input logic [QB-1:0] q, input logic neg);
        logic [XW-1:0] qe;
        logic [XW-1:0] qn;
        qe = XW'(q);
        qn = ~qe + 1'b1;
        if (neg) begin
            return (qe >= CSIGN) ? MIN_C : qn[C-1:0];
        end
        return (qe >= CSIGN) ? MAX_C : qe[C-1:0];
    endfunction

    // handshake and flow control
    logic r_skid_valid;
    logic r_ovalid;
    logic en;
    logic acc_in;
    logic acc_pt;
    logic proj_hold;

    // pipeline valid bits
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;
    logic [QB-1:0] r_dv;

    // stores and configuration
    logic signed [C-1:0]  r_view [wsp_pkg::MAT_ENTRIES];
    logic signed [C-1:0]  r_proj [wsp_pkg::MAT_ENTRIES];
    logic signed [C-1:0]  r_cam  [wsp_pkg::CAM_ENTRIES];
    logic [SB-1:0]        r_width;
    logic [SB-1:0]        r_height;
    logic                 cam_zero;
    logic signed [C-1:0]  pt [3];

    assign en          = !r_skid_valid;
    assign proj_hold   = (i_cmd == wsp_pkg::CMD_PROJ) && (r_v1 || r_v2);
    assign o_stall     = !en || proj_hold;
    assign acc_in      = i_valid && !o_stall;
    assign acc_pt      = acc_in && (i_cmd == wsp_pkg::CMD_PROJECT);
    assign o_cfg_ready = 1'b1;
    assign cam_zero    = (r_cam[0] == '0) && (r_cam[1] == '0) && (r_cam[2] == '0);
    assign pt[0]       = i_point_x;
    assign pt[1]       = i_point_y;
    assign pt[2]       = i_point_z;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= wsp_pkg::WIDTH_RESET;
            r_height <= wsp_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                wsp_pkg::CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                wsp_pkg::CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // matrix and camera stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < wsp_pkg::MAT_ENTRIES; i++) begin
                r_view[i] <= '0;
                r_proj[i] <= '0;
            end
            for (int i = 0; i < wsp_pkg::CAM_ENTRIES; i++) begin
                r_cam[i] <= '0;
            end
        end else if (acc_in) begin
            case (i_cmd)
                wsp_pkg::CMD_VIEW: r_view[i_elem_index] <= i_elem_value;
                wsp_pkg::CMD_PROJ: r_proj[i_elem_index] <= i_elem_value;
                wsp_pkg::CMD_CAMERA: begin
                    if (i_elem_index < 4'(wsp_pkg::CAM_ENTRIES)) begin
                        r_cam[i_elem_index[1:0]] <= i_elem_value;
                    end
                end
                default: ;
            endcase
        end
    end

    // valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8} <= '0;
            r_dv <= '0;
        end else if (en) begin
            r_v1 <= acc_pt;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
            r_dv <= {r_dv[QB-2:0], r_v8};
        end
    end

    // stage payload registers
    logic signed [PW-1:0]  r_p1 [16];
    logic signed [C-1:0]   r_s2 [16];
    logic signed [C-1:0]   r_t3 [4];
    logic signed [PW-1:0]  r_p4 [16];
    logic signed [C-1:0]   r_s5 [16];
    logic signed [C-1:0]   r_q6 [4];
    wsp_pkg::t_status      r_st1, r_st2, r_st3, r_st4, r_st5, r_st6, r_st7, r_st8;
    logic                  r_cl1, r_cl2, r_cl3, r_cl4, r_cl5, r_cl6;
    logic [C:0]            r_nx7, r_ny7, r_b7, r_b8;
    logic                  r_negx7, r_negy7, r_negx8, r_negy8;
    logic [AW-1:0]         r_ax8, r_ay8;
    wsp_pkg::t_status      r_dst  [QB];
    logic                  r_dnx  [QB];
    logic                  r_dny  [QB];

    // limit test and numerator terms of stage 7
    logic [C-1:0]          mw, mx, my;
    logic [C+1:0]          lim;
    logic signed [C:0]     nx, ny;
    logic                  outside;
    wsp_pkg::t_status      st7_next;

    always_comb begin
        mw      = mag_c(r_q6[3]);
        mx      = mag_c(r_q6[0]);
        my      = mag_c(r_q6[1]);
        lim     = {1'b0, mw, 1'b0} + (r_cl6 ? '0 : {2'b00, mw});
        outside = ({1'b0, mx, 1'b0} > lim) || ({1'b0, my, 1'b0} > lim);
        nx      = (C+1)'(r_q6[3]) + (C+1)'(r_q6[0]);
        ny      = (C+1)'(r_q6[3]) - (C+1)'(r_q6[1]);
        if (r_st6 != wsp_pkg::ST_VISIBLE) begin
            st7_next = r_st6;
        end else if (r_q6[3] == '0) begin
            st7_next = wsp_pkg::ST_W_ZERO;
        end else if (outside) begin
            st7_next = wsp_pkg::ST_OUTSIDE;
        end else begin
            st7_next = wsp_pkg::ST_VISIBLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1: view products, the w row passes its element through
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 4; i++) begin
                    r_p1[j*4+i] <= PW'(pt[j]) * PW'(r_view[j*4+i]);
                end
            end
            for (int i = 0; i < 4; i++) begin
                r_p1[12+i] <= {{(C-F){r_view[12+i][C-1]}}, r_view[12+i], {F{1'b0}}};
            end
            r_st1 <= cam_zero ? wsp_pkg::ST_CAM_INVALID : wsp_pkg::ST_VISIBLE;
            r_cl1 <= i_clamp_mode;

            // stage 2: truncate and saturate
            for (int i = 0; i < 16; i++) begin
                r_s2[i] <= trunc_sat(r_p1[i]);
            end
            r_st2 <= r_st1;
            r_cl2 <= r_cl1;

            // stage 3: view vector
            for (int i = 0; i < 4; i++) begin
                r_t3[i] <= sum_sat(r_s2[i], r_s2[4+i], r_s2[8+i], r_s2[12+i]);
            end
            r_st3 <= r_st2;
            r_cl3 <= r_cl2;

            // stage 4: projection products and behind-camera test
            for (int j = 0; j < 4; j++) begin
                for (int i = 0; i < 4; i++) begin
                    r_p4[j*4+i] <= PW'(r_t3[j]) * PW'(r_proj[j*4+i]);
                end
            end
            r_st4 <= (r_st3 == wsp_pkg::ST_VISIBLE && !r_t3[2][C-1]) ?
                     wsp_pkg::ST_BEHIND : r_st3;
            r_cl4 <= r_cl3;

            // stage 5
            for (int i = 0; i < 16; i++) begin
                r_s5[i] <= trunc_sat(r_p4[i]);
            end
            r_st5 <= r_st4;
            r_cl5 <= r_cl4;

            // stage 6: clip vector
            for (int i = 0; i < 4; i++) begin
                r_q6[i] <= sum_sat(r_s5[i], r_s5[4+i], r_s5[8+i], r_s5[12+i]);
            end
            r_st6 <= r_st5;
            r_cl6 <= r_cl5;

            // stage 7: limit test and numerator magnitudes
            r_st7   <= st7_next;
            r_nx7   <= mag_c1(nx);
            r_ny7   <= mag_c1(ny);
            r_negx7 <= nx[C] ^ r_q6[3][C-1];
            r_negy7 <= ny[C] ^ r_q6[3][C-1];
            r_b7    <= {mw, 1'b0};

            // stage 8: scale by viewport size
            r_ax8   <= AW'(r_nx7) * AW'(r_width);
            r_ay8   <= AW'(r_ny7) * AW'(r_height);
            r_b8    <= r_b7;
            r_st8   <= r_st7;
            r_negx8 <= r_negx7;
            r_negy8 <= r_negy7;

            // divider side line
            r_dst[0] <= r_st8;
            r_dnx[0] <= r_negx8;
            r_dny[0] <= r_negy8;
            for (int k = 1; k < QB; k++) begin
                r_dst[k] <= r_dst[k-1];
                r_dnx[k] <= r_dnx[k-1];
                r_dny[k] <= r_dny[k-1];
            end
        end
    end

    // viewport divides
    logic [QB-1:0] quo_x, quo_y;

    wsp_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({r_ax8, {F{1'b0}}}),
        .i_den (r_b8),
        .o_quo (quo_x)
    );

    wsp_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({r_ay8, {F{1'b0}}}),
        .i_den (r_b8),
        .o_quo (quo_y)
    );

    // final result word
    logic                 push;
    logic signed [C-1:0]  res_x, res_y;
    wsp_pkg::t_status     res_st;

    assign push   = en && r_dv[QB-1];
    assign res_st = r_dst[QB-1];
    assign res_x  = (res_st == wsp_pkg::ST_VISIBLE) ? to_coord(quo_x, r_dnx[QB-1]) : '0;
    assign res_y  = (res_st == wsp_pkg::ST_VISIBLE) ? to_coord(quo_y, r_dny[QB-1]) : '0;

    // output register and skid stage
    logic signed [C-1:0]  r_ox, r_oy, r_kx, r_ky;
    wsp_pkg::t_status     r_ost, r_kst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid     <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!i_stall) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_ovalid && i_stall) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_ovalid <= 1'b1;
            end
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (!i_stall) begin
                r_ox  <= r_kx;
                r_oy  <= r_ky;
                r_ost <= r_kst;
            end
        end else if (push) begin
            if (r_ovalid && i_stall) begin
                r_kx  <= res_x;
                r_ky  <= res_y;
                r_kst <= res_st;
            end else begin
                r_ox  <= res_x;
                r_oy  <= res_y;
                r_ost <= res_st;
            end
        end
    end

    assign o_valid    = r_ovalid;
    assign o_screen_x = r_ox;
    assign o_screen_y = r_oy;
    assign o_status   = r_ost;

    // checks
    `WSP_ASSERT_IMP(a_skid_has_out, i_clk, i_rst_n, r_skid_valid, r_ovalid)
    `WSP_ASSERT_IMP(a_reject_zero, i_clk, i_rst_n, o_valid && (o_status != wsp_pkg::ST_VISIBLE), (o_screen_x == '0) && (o_screen_y == '0))
    `WSP_ASSERT_IMP(a_no_accept_full, i_clk, i_rst_n, i_valid && !o_stall, !r_skid_valid)
    `WSP_ASSERT_NXT(a_proj_order, i_clk, i_rst_n, i_valid && !o_stall && (i_cmd == wsp_pkg::CMD_PROJ), !r_v2 && !r_v3)

endmodule
`default_nettype wire

// ----- rtl/wsp_div.sv -----
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module wsp_div #(
    parameter int COORD_BITS = wsp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = wsp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                                  i_clk,
    input  wire logic                                                  i_en,
    input  wire logic [COORD_BITS+wsp_pkg::SCALE_BITS+FRAC_BITS:0]     i_num,
    input  wire logic [COORD_BITS:0]                                   i_den,
    output logic      [wsp_pkg::SCALE_BITS+FRAC_BITS:0]                o_quo
);
    localparam int C  = COORD_BITS;
    localparam int QB = wsp_pkg::SCALE_BITS + FRAC_BITS + 1;
    localparam int DW = C + wsp_pkg::SCALE_BITS + FRAC_BITS + 1;

    logic [DW-1:0] r_rem [QB];
    logic [QB-1:0] r_quo [QB];
    logic [C:0]    r_den [QB];

    // stage k decides quotient bit QB-1-k
    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] sub_den;
        logic [QB-1:0] quo_in;
        logic [C:0]    den_in;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
            assign den_in = r_den[k-1];
        end

        assign sub_den = DW'(den_in) << (QB - 1 - k);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= den_in;
                if (rem_in >= sub_den) begin
                    r_rem[k] <= rem_in - sub_den;
                    r_quo[k] <= quo_in | (QB'(1) << (QB - 1 - k));
                end else begin
                    r_rem[k] <= rem_in;
                    r_quo[k] <= quo_in;
                end
            end
        end
    end

    assign o_quo = r_quo[QB-1];

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// self-checking testbench of the world to screen projection block
`timescale 1ns / 100ps
module tb;

    localparam int Q_ONE        = 65536;
    localparam int SETTLE_CYCLES = 60;
    localparam int WATCHDOG_MAX  = 20000;
    localparam int MAX_SHOWN     = 10;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        wsp_pkg::t_status   st;
    } t_screen_pt;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [1:0]               i_cmd = wsp_pkg::CMD_PROJECT;
    logic [3:0]               i_elem_index = '0;
    logic signed [31:0]       i_elem_value = '0;
    logic signed [31:0]       i_point_x = '0;
    logic signed [31:0]       i_point_y = '0;
    logic signed [31:0]       i_point_z = '0;
    logic                     i_clamp_mode = 1'b0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [31:0]       o_screen_x;
    logic signed [31:0]       o_screen_y;
    logic [2:0]               o_status;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic                     i_cfg_index = wsp_pkg::CFG_SCREEN_WIDTH;
    logic [wsp_pkg::SCALE_BITS-1:0] i_cfg_data = '0;

    // mirror of the block state
    logic signed [31:0]       view_m [wsp_pkg::MAT_ENTRIES];
    logic signed [31:0]       proj_m [wsp_pkg::MAT_ENTRIES];
    logic signed [31:0]       cam_m  [wsp_pkg::CAM_ENTRIES];
    logic [wsp_pkg::SCALE_BITS-1:0] width_m;
    logic [wsp_pkg::SCALE_BITS-1:0] height_m;

    t_screen_pt               pending_pts [$];
    int                       mismatches = 0;
    int                       tx_idle_pct = 0;
    int                       rx_idle_pct = 0;
    int                       quiet_cycles = 0;

    world_to_screen_projection dut (.*);

    always #1 i_clk = ~i_clk;

    // fixed point helpers
    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint p;
        longint m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = m >>> 16;
        return sat32((p < 0) ? -m : m);
    endfunction

    function automatic longint screen_coord(longint c, longint w, longint scale);
        longint     n;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] q;
        bit          neg;
        n = w + c;
        neg = ((n < 0) != (w < 0)) && (n != 0);
        a = ((n < 0) ? -n : n) * scale;
        b = 2 * ((w < 0) ? -w : w);
        q = (a << 16) / b;
        if (neg) return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
        return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
    endfunction

    // expected screen position of one world point
    function automatic t_screen_pt project_point(longint px, longint py, longint pz,
                                                 bit clamp);
        longint     p [4];
        longint     t [4];
        longint     q [4];
        longint     acc;
        longint     lim;
        t_screen_pt r;
        p[0] = px; p[1] = py; p[2] = pz; p[3] = Q_ONE;
        r.sx = '0;
        r.sy = '0;
        if (cam_m[0] == 0 && cam_m[1] == 0 && cam_m[2] == 0) begin
            r.st = wsp_pkg::ST_CAM_INVALID;
            return r;
        end
        for (int i = 0; i < 4; i++) begin
            acc = 0;
            for (int j = 0; j < 4; j++) acc += qmul(p[j], view_m[j*4+i]);
            t[i] = sat32(acc);
        end
        if (t[2] >= 0) begin
            r.st = wsp_pkg::ST_BEHIND;
            return r;
        end
        for (int i = 0; i < 4; i++) begin
            acc = 0;
            for (int j = 0; j < 4; j++) acc += qmul(t[j], proj_m[j*4+i]);
            q[i] = sat32(acc);
        end
        if (q[3] == 0) begin
            r.st = wsp_pkg::ST_W_ZERO;
            return r;
        end
        lim = (q[3] < 0) ? -q[3] : q[3];
        lim = clamp ? 2 * lim : 3 * lim;
        if (2 * ((q[0] < 0) ? -q[0] : q[0]) > lim || 2 * ((q[1] < 0) ? -q[1] : q[1]) > lim)
        begin
            r.st = wsp_pkg::ST_OUTSIDE;
            return r;
        end
        r.st = wsp_pkg::ST_VISIBLE;
        r.sx = screen_coord(q[0], q[3], width_m);
        r.sy = screen_coord(-q[1], q[3], height_m);
        return r;
    endfunction

    // send one word, stalling as the block asks
    task automatic send_word(wsp_pkg::t_cmd c, logic [3:0] idx, logic [31:0] val,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz, bit clamp);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_cmd = c;
        i_elem_index = idx;
        i_elem_value = val;
        i_point_x = px;
        i_point_y = py;
        i_point_z = pz;
        i_clamp_mode = clamp;
        do @(posedge i_clk); while (o_stall);
        case (c)
            wsp_pkg::CMD_PROJECT: begin
                pending_pts.push_back(project_point(longint'($signed(px)),
                    longint'($signed(py)), longint'($signed(pz)), clamp));
            end
            wsp_pkg::CMD_VIEW:    view_m[idx] = val;
            wsp_pkg::CMD_PROJ:    proj_m[idx] = val;
            wsp_pkg::CMD_CAMERA:  if (idx < wsp_pkg::CAM_ENTRIES) cam_m[idx] = val;
            default: ;
        endcase
    endtask

    task automatic load_word(wsp_pkg::t_cmd c, logic [3:0] idx, logic [31:0] val);
        send_word(c, idx, val, $urandom, $urandom, $urandom, $urandom_range(1));
    endtask

    task automatic point_word(int px, int py, int pz, bit clamp);
        send_word(wsp_pkg::CMD_PROJECT, $urandom, $urandom, px, py, pz, clamp);
    endtask

    task automatic hold_input();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // wait until every pending result has come, then let the pipe drain
    task automatic drain();
        hold_input();
        while (pending_pts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(wsp_pkg::t_cfg_reg idx, logic [wsp_pkg::SCALE_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == wsp_pkg::CFG_SCREEN_WIDTH) width_m = val;
        else height_m = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_viewport(logic [wsp_pkg::SCALE_BITS-1:0] w,
                                logic [wsp_pkg::SCALE_BITS-1:0] h);
        drain();
        write_cfg(wsp_pkg::CFG_SCREEN_WIDTH, w);
        write_cfg(wsp_pkg::CFG_SCREEN_HEIGHT, h);
    endtask

    // camera, view and perspective projection with random content
    task automatic load_scene();
        int f;
        load_word(wsp_pkg::CMD_CAMERA, 0, $urandom_range(1) ? $urandom | 1 : 0);
        load_word(wsp_pkg::CMD_CAMERA, 1, $urandom_range(3) == 0 ? 0 : $urandom);
        load_word(wsp_pkg::CMD_CAMERA, 2, $urandom | 32'h100);
        for (int i = 0; i < wsp_pkg::MAT_ENTRIES; i++) begin
            if (i % 5 == 0) load_word(wsp_pkg::CMD_VIEW, i, Q_ONE);
            else if (i >= 12 || $urandom_range(3) == 0)
                load_word(wsp_pkg::CMD_VIEW, i,
                          $signed($urandom_range(20 * Q_ONE)) - 10 * Q_ONE);
            else load_word(wsp_pkg::CMD_VIEW, i, 0);
        end
        f = $urandom_range(3 * Q_ONE, Q_ONE / 2);
        for (int i = 0; i < wsp_pkg::MAT_ENTRIES; i++) begin
            case (i)
                0, 5:    load_word(wsp_pkg::CMD_PROJ, i, f);
                10, 14:  load_word(wsp_pkg::CMD_PROJ, i,
                                   $signed($urandom_range(4 * Q_ONE)) - 2 * Q_ONE);
                11:      load_word(wsp_pkg::CMD_PROJ, i, -Q_ONE);
                default: load_word(wsp_pkg::CMD_PROJ, i,
                                   $urandom_range(7) == 0 ? $urandom_range(4096) : 0);
            endcase
        end
    endtask

    task automatic test_reset_state();
        // zero camera after reset, default viewport
        point_word(0, 0, -Q_ONE, 1'b1);
        point_word(32'h7fffffff, 32'h80000000, 32'h80000000, 1'b0);
        drain();
    endtask

    task automatic test_directed();
        // camera writes above index two are dropped
        load_word(wsp_pkg::CMD_CAMERA, 15, 32'h12345678);
        load_word(wsp_pkg::CMD_CAMERA, 3, 32'hffffffff);
        point_word(Q_ONE, Q_ONE, -Q_ONE, 1'b1);
        load_word(wsp_pkg::CMD_CAMERA, 2, 32'h80000000);
        for (int i = 0; i < wsp_pkg::MAT_ENTRIES; i++)
            load_word(wsp_pkg::CMD_VIEW, i, (i % 5 == 0) ? Q_ONE : 0);
        for (int i = 0; i < wsp_pkg::MAT_ENTRIES; i++)
            load_word(wsp_pkg::CMD_PROJ, i,
                      (i == 0 || i == 5) ? Q_ONE : (i == 11) ? -Q_ONE : 0);
        // visible, center and the edges of both limits
        point_word(0, 0, -5 * Q_ONE, 1'b1);
        point_word(5 * Q_ONE, -5 * Q_ONE, -5 * Q_ONE, 1'b1);
        point_word(7 * Q_ONE, 7 * Q_ONE, -5 * Q_ONE, 1'b1);
        point_word(7 * Q_ONE, -7 * Q_ONE, -5 * Q_ONE, 1'b0);
        point_word(8 * Q_ONE, 0, -5 * Q_ONE, 1'b0);
        // behind camera, at zero and in front of the plane
        point_word(0, 0, 0, 1'b1);
        point_word(0, 0, 32'h7fffffff, 1'b0);
        // saturating extremes
        point_word(32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0);
        point_word(32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b1);
        // projected w is zero
        load_word(wsp_pkg::CMD_PROJ, 11, 0);
        point_word(Q_ONE, Q_ONE, -3 * Q_ONE, 1'b1);
        load_word(wsp_pkg::CMD_PROJ, 11, 32'h80000000);
        point_word(0, 0, -1, 1'b0);
        load_word(wsp_pkg::CMD_PROJ, 11, -Q_ONE);
        // zero viewport, then other viewport sizes
        set_viewport(0, 0);
        point_word(Q_ONE, Q_ONE, -2 * Q_ONE, 1'b1);
        set_viewport(8192, 1);
        point_word(-Q_ONE, Q_ONE / 3, -2 * Q_ONE, 1'b0);
        set_viewport(16383, 8192);
        point_word(Q_ONE / 7, -Q_ONE, -Q_ONE, 1'b0);
        drain();
    endtask

    task automatic test_random(int n_items, int tx_pct, int rx_pct);
        int sent;
        int zv;
        sent = 0;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        load_scene();
        sent += 35;
        while (sent < n_items) begin
            if ($urandom_range(39) == 0) begin
                load_scene();
                sent += 35;
            end else if ($urandom_range(9) == 0) begin
                // noise over the whole input space
                send_word(wsp_pkg::t_cmd'($urandom_range(3)), $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom_range(1));
                sent++;
            end else begin
                zv = $urandom_range(200 * Q_ONE, 1);
                point_word($signed($urandom_range(4 * zv)) - 2 * zv,
                           $signed($urandom_range(4 * zv)) - 2 * zv,
                           $urandom_range(15) == 0 ? $urandom_range(Q_ONE) : -zv,
                           $urandom_range(1));
                sent++;
            end
        end
        drain();
    endtask

    // receiver stall
    always @(negedge i_clk) i_stall = ($urandom_range(99) < rx_idle_pct);

    // result checker
    always @(posedge i_clk) begin
        t_screen_pt exp_pt;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pts.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) $display("unexpected result word");
            end else begin
                exp_pt = pending_pts.pop_front();
                if (o_screen_x !== exp_pt.sx || o_screen_y !== exp_pt.sy ||
                    o_status !== exp_pt.st) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("result mismatch: expected x %h y %h st %0d, got x %h y %h st %0d",
                                 exp_pt.sx, exp_pt.sy, exp_pt.st,
                                 o_screen_x, o_screen_y, o_status);
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < wsp_pkg::MAT_ENTRIES; i++) begin
            view_m[i] = '0;
            proj_m[i] = '0;
        end
        for (int i = 0; i < wsp_pkg::CAM_ENTRIES; i++) cam_m[i] = '0;
        width_m = wsp_pkg::WIDTH_RESET;
        height_m = wsp_pkg::HEIGHT_RESET;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_state();
        test_directed();
        set_viewport(1920, 1080);
        test_random(550, 16, 48);
        set_viewport($urandom_range(8192, 1), $urandom_range(8192, 1));
        test_random(550, 48, 16);
        set_viewport(8192, 8192);
        test_random(550, 0, 0);
        if (mismatches == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
